/* src/bha_pkg.sv */
`timescale 1ns / 1ps

package bha_pkg;

  // request kinds carried on the input tuser bit
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  // signed width for size compares, width of a block count
  localparam int SIZE_W = 18;
  localparam int BLK_W  = 13;

  // byte size that still fits one block, and the block count base above it
  localparam int SMALL_BYTES = 8;
  localparam int BLK_BASE    = 2;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_RESP,
    A_HEAD,
    A_WALK,
    A_BEST,
    A_UL_P,
    A_UL_N,
    A_UL_C,
    A_SP_END,
    A_SP_NB,
    A_SP_CF,
    A_T_ZERO,
    A_T_RD,
    A_T_FP,
    A_T_RD2,
    A_T_E,
    A_T_CF,
    F_POS,
    F_N,
    F_UL_P,
    F_UL_N,
    F_UL_C,
    F_NN,
    F_POSL,
    F_POS2,
    F_P,
    F_MP,
    F_MNX,
    F_HEAD,
    F_H,
    F_PUSH
  } bha_state_t;

  // final step of a free: link entry 0 to the pushed block
  localparam bha_state_t F_ZERO_ALIAS = F_PUSH;

endpackage

/* src/block_heap_allocator_unit.sv */
`timescale 1ns / 1ps

// Block heap allocator. Manages NUM_BLOCKS blocks of 16 bytes through one
// table memory whose word holds, per block, the next block index with a free
// mark, the previous block index and the two free-list links; entry 0 heads
// the free list. An input word asks to allocate (in_tuser 0, size in bytes)
// or to free (in_tuser 1, first block index); each word gives exactly one
// result word: the first block index of the region (0 on failure and on
// every free) and an ok flag in out_tuser. After reset the table is cleared
// one entry a cycle, so no word is taken until every entry is cleared;
// fit_mode can be written at any time (1 best fit, 0 first fit). The table
// has a single port with a registered read, and every table update is a
// read followed by a write, so one word is worked on at a time. An allocate
// walks the free list one entry per cycle and then, when it succeeds,
// updates the table; a zero size is answered without a walk. A free updates
// the table unless its index is zero or out of range. A result waiting in
// the output register lets the next word in; the next result waits for it.
module block_heap_allocator_unit
  import bha_pkg::*;
#(
  parameter int NUM_BLOCKS = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  // request_bytes [15:0], free_block [27:16], zero pad [31:28]
  input  logic [31:0] in_tdata,
  // action
  input  logic        in_tuser,
  input  logic        in_tvalid,
  output logic        in_tready,
  // result_block [11:0], zero pad [15:12]
  output logic [15:0] out_tdata,
  // ok
  output logic        out_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data
);

  localparam int AW  = $clog2(NUM_BLOCKS);
  localparam int AW1 = AW + 1;
  localparam logic [AW:0]   STEPS_LIM = AW1'(NUM_BLOCKS);
  localparam logic [AW-1:0] LAST_IDX  = AW'(NUM_BLOCKS - 1);

  // one table entry: free mark, next, previous, free next, free previous
  typedef struct packed {
    logic          mark;
    logic [AW-1:0] nxt;
    logic [AW-1:0] prv;
    logic [AW-1:0] fnx;
    logic [AW-1:0] fpv;
  } word_t;

  // table memory
  word_t         mem [NUM_BLOCKS];
  word_t         rw;          // registered read data
  logic          mem_re, mem_we;
  logic [AW-1:0] mem_raddr, mem_waddr;
  word_t         mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rw <= mem[mem_raddr];
    end
  end

  // control state
  bha_state_t state_r, state_nxt;
  logic       ph_r, ph_nxt;       // 0 read issue, 1 data back / write
  logic [AW-1:0] clr_r;
  logic       fit_mode_r;

  // working registers
  logic [AW-1:0] cf_r, cf_nxt;
  logic [AW-1:0] best_r, best_nxt;
  logic signed [SIZE_W-1:0] bsize_r, bsize_nxt;
  logic [BLK_W-1:0] blocks_r, blocks_nxt;
  logic       found_r, found_nxt;
  logic [AW:0] steps_r, steps_nxt;
  logic [AW-1:0] p_r, p_nxt;
  logic [AW-1:0] n_r, n_nxt;
  logic [AW-1:0] nb_r, nb_nxt;
  logic [AW-1:0] ea_r, ea_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  word_t      wd_r, wd_nxt;
  logic [11:0] res_blk_r, res_blk_nxt;
  logic       res_ok_r, res_ok_nxt;

  // output register
  logic [11:0] out_blk_r;
  logic       out_ok_r, out_vld_r;

  // input fields
  logic          in_act;
  logic [15:0]   in_bytes;
  logic [11:0]   in_blk;
  logic [15:0]   bytes_m9;
  logic [BLK_W-1:0] req_blocks;
  logic          pos_bad;

  assign in_act   = in_tuser;
  assign in_bytes = in_tdata[15:0];
  assign in_blk   = in_tdata[27:16];
  assign bytes_m9 = in_bytes - 16'd9;
  assign req_blocks = (in_bytes <= 16'(SMALL_BYTES)) ? BLK_W'(1)
                    : BLK_W'(BLK_BASE) + BLK_W'(bytes_m9 >> 4);
  assign pos_bad  = (in_blk == 12'd0) || (17'(in_blk) >= 17'(NUM_BLOCKS));

  logic accept, resp_go;
  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign resp_go   = (state_r == S_RESP) && (!out_vld_r || out_tready);

  // free-list walk decisions, on the entry just read back
  logic signed [SIZE_W-1:0] size_s, blk_s;
  logic fits, take, ff_hit, walk_end, steps_over, tail_full;
  logic [SIZE_W-1:0] tail_sum;

  assign size_s     = $signed(SIZE_W'(rw.nxt)) - $signed(SIZE_W'(cf_r));
  assign blk_s      = $signed(SIZE_W'(blocks_r));
  assign fits       = size_s >= blk_s;
  assign ff_hit     = fits && !fit_mode_r;
  assign take       = fits && (!fit_mode_r || !found_r || (size_s < bsize_r));
  assign walk_end   = (rw.fnx == '0);
  assign steps_over = steps_r >= STEPS_LIM;
  assign tail_sum   = SIZE_W'(cf_r) + SIZE_W'(blocks_r) + SIZE_W'(1);
  assign tail_full  = tail_sum >= SIZE_W'(NUM_BLOCKS);

  // table address of the current step
  logic [AW-1:0] acc_addr;
  logic is_rd, is_rmw;

  always_comb begin
    acc_addr = '0;
    is_rd    = 1'b0;
    is_rmw   = 1'b0;
    case (state_r)
      A_HEAD:   begin acc_addr = '0;     is_rd  = 1'b1; end
      A_BEST:   begin acc_addr = best_r; is_rd  = 1'b1; end
      A_UL_P:   begin acc_addr = p_r;    is_rmw = 1'b1; end
      A_UL_N:   begin acc_addr = n_r;    is_rmw = 1'b1; end
      A_UL_C:   begin acc_addr = cf_r;   is_rmw = 1'b1; end
      A_SP_END: begin acc_addr = ea_r;   is_rmw = 1'b1; end
      A_SP_NB:  begin acc_addr = nb_r;   is_rmw = 1'b1; end
      A_SP_CF:  begin acc_addr = cf_r;   is_rmw = 1'b1; end
      A_T_ZERO: begin acc_addr = '0;     is_rmw = 1'b1; end
      A_T_RD:   begin acc_addr = cf_r;   is_rd  = 1'b1; end
      A_T_FP:   begin acc_addr = p_r;    is_rmw = 1'b1; end
      A_T_RD2:  begin acc_addr = cf_r;   is_rd  = 1'b1; end
      A_T_E:    acc_addr = ea_r;
      A_T_CF:   acc_addr = cf_r;
      F_POS:    begin acc_addr = pos_r;  is_rd  = 1'b1; end
      F_N:      begin acc_addr = n_r;    is_rd  = 1'b1; end
      F_UL_P:   begin acc_addr = p_r;    is_rmw = 1'b1; end
      F_UL_N:   begin acc_addr = nb_r;   is_rmw = 1'b1; end
      F_UL_C:   begin acc_addr = n_r;    is_rmw = 1'b1; end
      F_NN:     begin acc_addr = ea_r;   is_rmw = 1'b1; end
      F_POSL:   begin acc_addr = pos_r;  is_rmw = 1'b1; end
      F_POS2:   begin acc_addr = pos_r;  is_rd  = 1'b1; end
      F_P:      begin acc_addr = p_r;    is_rd  = 1'b1; end
      F_MP:     begin acc_addr = p_r;    is_rmw = 1'b1; end
      F_MNX:    begin acc_addr = nb_r;   is_rmw = 1'b1; end
      F_HEAD:   begin acc_addr = '0;     is_rd  = 1'b1; end
      F_H:      begin acc_addr = ea_r;   is_rmw = 1'b1; end
      F_PUSH:   begin acc_addr = pos_r;  is_rmw = 1'b1; end
      default:  acc_addr = '0;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    ph_nxt    = 1'b0;
    case (state_r)
      S_CLEAR: begin
        if (clr_r == LAST_IDX) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          if (in_act == ACT_FREE) begin
            state_nxt = pos_bad ? S_RESP : F_POS;
          end else begin
            state_nxt = (in_bytes == 16'd0) ? S_RESP : A_HEAD;
          end
        end
      end
      S_RESP: begin
        if (resp_go) state_nxt = S_IDLE;
      end
      A_WALK: begin
        if (walk_end) begin
          if (found_r)              state_nxt = A_BEST;
          else if (rw.nxt != '0)    state_nxt = S_RESP;
          else if (tail_full)       state_nxt = S_RESP;
          else if (cf_r == '0)      state_nxt = A_T_ZERO;
          else                      state_nxt = A_T_RD;
        end else if (steps_over) begin
          state_nxt = S_RESP;
        end else if (ff_hit) begin
          state_nxt = A_BEST;
        end
      end
      A_T_E:  state_nxt = A_T_CF;
      A_T_CF: state_nxt = S_RESP;
      default: begin
        if (!ph_r) begin
          ph_nxt = 1'b1;
        end else begin
          case (state_r)
            A_HEAD:   state_nxt = A_WALK;
            A_BEST:   state_nxt = (bsize_r == blk_s) ? A_UL_P : A_SP_END;
            A_UL_P:   state_nxt = A_UL_N;
            A_UL_N:   state_nxt = A_UL_C;
            A_UL_C:   state_nxt = S_RESP;
            A_SP_END: state_nxt = A_SP_NB;
            A_SP_NB:  state_nxt = A_SP_CF;
            A_SP_CF:  state_nxt = S_RESP;
            A_T_ZERO: state_nxt = A_T_RD;
            A_T_RD:   state_nxt = A_T_FP;
            A_T_FP:   state_nxt = A_T_RD2;
            A_T_RD2:  state_nxt = A_T_E;
            F_POS:    state_nxt = F_N;
            F_N:      state_nxt = rw.mark ? F_UL_P : F_POS2;
            F_UL_P:   state_nxt = F_UL_N;
            F_UL_N:   state_nxt = F_UL_C;
            F_UL_C:   state_nxt = F_NN;
            F_NN:     state_nxt = F_POSL;
            F_POSL:   state_nxt = F_POS2;
            F_POS2:   state_nxt = F_P;
            F_P:      state_nxt = rw.mark ? F_MP : F_HEAD;
            F_MP:     state_nxt = F_MNX;
            F_MNX:    state_nxt = S_RESP;
            F_HEAD:   state_nxt = F_H;
            F_H:      state_nxt = F_PUSH;
            F_PUSH:   begin
              // entry 0 still has to point at the pushed block
              state_nxt = wd_r.mark ? S_RESP : F_ZERO_ALIAS;
            end
            default:  state_nxt = S_IDLE;
          endcase
        end
      end
    endcase
  end

  // table access and working registers
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = acc_addr;
    mem_we    = 1'b0;
    mem_waddr = acc_addr;
    mem_wdata = rw;
    cf_nxt     = cf_r;
    best_nxt   = best_r;
    bsize_nxt  = bsize_r;
    blocks_nxt = blocks_r;
    found_nxt  = found_r;
    steps_nxt  = steps_r;
    p_nxt      = p_r;
    n_nxt      = n_r;
    nb_nxt     = nb_r;
    ea_nxt     = ea_r;
    pos_nxt    = pos_r;
    wd_nxt     = wd_r;
    res_blk_nxt = res_blk_r;
    res_ok_nxt  = res_ok_r;

    if ((is_rd || is_rmw) && !ph_r) mem_re = 1'b1;
    if (is_rmw && ph_r) mem_we = 1'b1;

    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
      end
      S_IDLE: begin
        pos_nxt     = AW'(in_blk);
        blocks_nxt  = req_blocks;
        res_blk_nxt = 12'd0;
        res_ok_nxt  = (in_act == ACT_FREE);
        wd_nxt.mark = 1'b0;
      end
      A_HEAD: begin
        if (ph_r) begin
          cf_nxt    = rw.fnx;
          best_nxt  = rw.fnx;
          steps_nxt = '0;
          found_nxt = 1'b0;
          mem_re    = 1'b1;
          mem_raddr = rw.fnx;
        end
      end
      A_WALK: begin
        if (walk_end) begin
          if (!found_r && rw.nxt == '0 && !tail_full && cf_r != '0) begin
            res_blk_nxt = 12'(cf_r);
          end
        end else if (!steps_over) begin
          steps_nxt = steps_r + 1'b1;
          if (take) begin
            best_nxt  = cf_r;
            bsize_nxt = size_s;
            found_nxt = 1'b1;
          end
          if (!ff_hit) begin
            cf_nxt    = rw.fnx;
            mem_re    = 1'b1;
            mem_raddr = rw.fnx;
          end
        end
      end
      A_BEST: begin
        if (ph_r) begin
          cf_nxt = best_r;
          p_nxt  = rw.fpv;
          n_nxt  = rw.fnx;
          nb_nxt = rw.nxt;
          ea_nxt = AW'(bsize_r + $signed(SIZE_W'(best_r)) - blk_s);
        end
      end
      A_UL_P:   mem_wdata.fnx = n_r;
      A_UL_N:   mem_wdata.fpv = p_r;
      A_UL_C: begin
        mem_wdata.mark = 1'b0;
        res_blk_nxt    = 12'(cf_r);
        res_ok_nxt     = 1'b1;
      end
      A_SP_END: begin
        mem_wdata.mark = 1'b0;
        mem_wdata.nxt  = nb_r;
        mem_wdata.prv  = cf_r;
      end
      A_SP_NB:  mem_wdata.prv = ea_r;
      A_SP_CF: begin
        mem_wdata.nxt  = ea_r;
        mem_wdata.mark = (ea_r != '0);
        res_blk_nxt    = 12'(ea_r);
        res_ok_nxt     = 1'b1;
      end
      A_T_ZERO: begin
        mem_wdata.mark = 1'b0;
        mem_wdata.nxt  = AW'(1);
        mem_wdata.fnx  = AW'(1);
        cf_nxt         = AW'(1);
      end
      A_T_RD: begin
        if (ph_r) begin
          p_nxt  = rw.fpv;
          ea_nxt = AW'(SIZE_W'(cf_r) + SIZE_W'(blocks_r));
        end
      end
      A_T_FP:   mem_wdata.fnx = ea_r;
      A_T_RD2: begin
        if (ph_r) wd_nxt = rw;
      end
      A_T_E: begin
        // tail entry moves up past the new region
        mem_we    = 1'b1;
        mem_wdata = '{mark: wd_r.mark, nxt: wd_r.nxt, prv: cf_r,
                      fnx: wd_r.fnx, fpv: wd_r.fpv};
      end
      A_T_CF: begin
        mem_we      = 1'b1;
        mem_wdata   = '{mark: 1'b0, nxt: ea_r, prv: wd_r.prv,
                        fnx: wd_r.fnx, fpv: wd_r.fpv};
        res_blk_nxt = 12'(cf_r);
        res_ok_nxt  = 1'b1;
      end
      F_POS: begin
        if (ph_r) n_nxt = rw.nxt;
      end
      F_N: begin
        if (ph_r) begin
          p_nxt  = rw.fpv;
          nb_nxt = rw.fnx;
        end
      end
      F_UL_P:   mem_wdata.fnx = nb_r;
      F_UL_N:   mem_wdata.fpv = p_r;
      F_UL_C: begin
        mem_wdata.mark = 1'b0;
        if (ph_r) ea_nxt = rw.nxt;
      end
      F_NN:     mem_wdata.prv = pos_r;
      F_POSL: begin
        mem_wdata.mark = 1'b0;
        mem_wdata.nxt  = ea_r;
      end
      F_POS2: begin
        if (ph_r) begin
          p_nxt  = rw.prv;
          nb_nxt = rw.nxt;
        end
      end
      F_MP: begin
        mem_wdata.nxt  = nb_r;
        mem_wdata.mark = (nb_r != '0);
      end
      F_MNX:    mem_wdata.prv = p_r;
      F_HEAD: begin
        if (ph_r) ea_nxt = rw.fnx;
      end
      F_H:      mem_wdata.fpv = pos_r;
      F_PUSH: begin
        if (!wd_r.mark) begin
          // first pass: push the block, second pass: head points at it
          mem_wdata.fnx  = ea_r;
          mem_wdata.fpv  = '0;
          mem_wdata.mark = (rw.nxt != '0);
          if (ph_r) wd_nxt.mark = 1'b1;
        end else begin
          mem_raddr      = '0;
          mem_waddr      = '0;
          mem_wdata.fnx  = pos_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      ph_r       <= 1'b0;
      clr_r      <= '0;
      fit_mode_r <= 1'b1;
      out_vld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ph_r    <= ph_nxt;
      if (state_r == S_CLEAR) clr_r <= clr_r + 1'b1;
      if (cfg_wr_en) fit_mode_r <= cfg_wr_data;
      if (resp_go) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cf_r      <= cf_nxt;
    best_r    <= best_nxt;
    bsize_r   <= bsize_nxt;
    blocks_r  <= blocks_nxt;
    found_r   <= found_nxt;
    steps_r   <= steps_nxt;
    p_r       <= p_nxt;
    n_r       <= n_nxt;
    nb_r      <= nb_nxt;
    ea_r      <= ea_nxt;
    pos_r     <= pos_nxt;
    wd_r      <= wd_nxt;
    res_blk_r <= res_blk_nxt;
    res_ok_r  <= res_ok_nxt;
    if (resp_go) begin
      out_blk_r <= res_blk_r;
      out_ok_r  <= res_ok_r;
    end
  end

  assign out_tdata  = {4'd0, out_blk_r};
  assign out_tuser  = out_ok_r;
  assign out_tvalid = out_vld_r;

endmodule
